/* rtl/wljp_pkg.sv */
package wljp_pkg;

    // table size; the index, count and prefix widths follow from it
    localparam int MAX_JOBS  = 64;
    localparam int IDX_W     = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int REC_W     = 6;
    localparam int WGT_W     = 16;
    localparam int PW        = WGT_W + IDX_W;      // prefix / total width
    localparam int FRAC_W    = 53;
    localparam int FRAC_LO_W = (FRAC_W + 1) / 2;   // low partial product slice
    localparam int FRAC_HI_W = FRAC_W - FRAC_LO_W;
    localparam int JOBS_W    = 7;

    localparam int S_TDATA_W = ((REC_W + WGT_W + FRAC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((REC_W + 2 + JOBS_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_PICK = 1'b1
    } req_t;

    // item as it travels down the pipeline
    typedef struct packed {
        logic             vld;
        logic             pick;    // pick on a non-empty table with nonzero total
        logic             full;    // refused add
        logic [CNT_W-1:0] cnt;     // job count after this item
        logic [PW-1:0]    total;   // total weight seen by a pick
        logic [FRAC_W-1:0] frac;
        logic [PW-1:0]    q;       // floor(frac * total / 2^53)
        logic [IDX_W-1:0] idx;     // search result so far
    } pipe_t;

    // table append, shared by all table copies
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [PW-1:0]    prefix;
        logic [REC_W-1:0] rec;
    } wr_t;

    // result item, last field in the low bits
    typedef struct packed {
        logic [JOBS_W-1:0] jobs;
        logic              full;
        logic              found;
        logic [REC_W-1:0]  picked;
    } res_t;

endpackage

/* rtl/wljp_ram.sv */
module wljp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 22
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wljp_mul.sv */
module wljp_mul import wljp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t in_item,
    output pipe_t out_item
);

    pipe_t                       p1_reg;
    pipe_t                       p2_reg;
    pipe_t                       p2_next;
    logic [FRAC_HI_W+PW-1:0]     hi_reg;
    logic [FRAC_LO_W+PW-1:0]     lo_reg;
    logic [FRAC_W+PW-1:0]        sum;

    // two partial products, each well under 32x32
    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg <= in_item.frac[FRAC_W-1:FRAC_LO_W] * in_item.total;
            lo_reg <= in_item.frac[FRAC_LO_W-1:0] * in_item.total;
        end
    end

    assign sum = {hi_reg, {FRAC_LO_W{1'b0}}} + (FRAC_W + PW)'(lo_reg);

    always_comb begin
        p2_next   = p1_reg;
        p2_next.q = sum[FRAC_W +: PW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= '0;
            p2_reg <= '0;
        end else if (en) begin
            p1_reg <= in_item;
            p2_reg <= p2_next;
        end
    end

    assign out_item = p2_reg;

endmodule

/* rtl/wljp_search.sv */
module wljp_search import wljp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  wr_t   wr,
    input  pipe_t in_item,
    output pipe_t out_item
);

    // one stage per index bit, msb first; idx counts prefixes <= q
    pipe_t stage_in [IDX_W];
    pipe_t res      [IDX_W];

    genvar k;
    generate
        for (k = 0; k < IDX_W; k++) begin : g_stage
            localparam int B = IDX_W - 1 - k;

            pipe_t            st_reg;
            pipe_t            res_c;
            logic [IDX_W-1:0] probe;
            logic [IDX_W-1:0] probe_reg;
            logic [IDX_W-1:0] addr;
            logic             ok_reg;
            logic [PW-1:0]    rd;

            if (k == 0) begin : g_first
                assign stage_in[k] = in_item;
            end else begin : g_next
                assign stage_in[k] = res[k-1];
            end

            // lower bits are still clear, so the add is an or
            assign probe = stage_in[k].idx | (IDX_W'(1) << B);
            assign addr  = probe - IDX_W'(1);

            wljp_ram #(
                .DEPTH(MAX_JOBS),
                .WIDTH(PW)
            ) u_ram (
                .aclk  (aclk),
                .we    (wr.en),
                .waddr (wr.addr),
                .wdata (wr.prefix),
                .re    (en),
                .raddr (addr),
                .rdata (rd)
            );

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    st_reg <= '0;
                end else if (en) begin
                    st_reg <= stage_in[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    probe_reg <= probe;
                    ok_reg    <= (CNT_W'(probe) <= stage_in[k].cnt);
                end
            end

            always_comb begin
                res_c = st_reg;
                if (ok_reg && (rd <= st_reg.q)) begin
                    res_c.idx = probe_reg;
                end
            end

            assign res[k] = res_c;
        end
    endgenerate

    assign out_item = res[IDX_W-1];

    // the last prefix equals the total, which always exceeds q
    a_idx_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_item.vld && out_item.pick) |-> (CNT_W'(out_item.idx) < out_item.cnt))
        else $error("pick index beyond table");

endmodule

/* rtl/wljp_outq.sv */
module wljp_outq import wljp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_item,
    output logic room,
    output logic out_vld,
    output res_t out_item,
    input  logic pop_rdy
);

    res_t       ent_reg [2];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign out_vld  = (cnt_reg != 2'd0);
    assign out_item = ent_reg[rp_reg];
    assign pop      = out_vld && pop_rdy;
    assign room     = (cnt_reg != 2'd2) || pop_rdy;

    assign wp_next  = push ? ~wp_reg : wp_reg;
    assign rp_next  = pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((cnt_reg != 2'd2) || pop))
        else $error("output queue overrun");

endmodule

/* rtl/weighted_lottery_job_picker.sv */
// Path: an accepted input item passes through the input register, two multiply stages,
// one table lookup stage per index bit of the binary search, and the record lookup.
// Throughput: one item per cycle while the output queue has room; its two entries keep
// the input open while one result waits. Reset (aresetn low, synchronous) empties the
// table at once; table contents are not cleared, and no clearing pass is needed.
module weighted_lottery_job_picker import wljp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // record_index, node_count, random_fraction, 0 pad
    input  logic                 s_tuser,   // req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // picked_record, found, table_full, active_jobs, 0 pad
);

    logic             en;          // whole pipeline advances
    logic             acc;
    logic             is_add;
    logic             full_now;
    logic [CNT_W-1:0] job_count_reg;
    logic [CNT_W-1:0] job_count_next;
    logic [PW-1:0]    total_reg;
    logic [PW-1:0]    total_next;
    wr_t              wr;
    pipe_t            in_reg;
    pipe_t            in_next;
    pipe_t            mul_out;
    pipe_t            srch_out;
    pipe_t            fin_reg;
    logic [REC_W-1:0] rec_rd;
    res_t             res;
    res_t             out_item;

    assign s_tready = en && aresetn;
    assign acc      = s_tvalid && s_tready;
    assign is_add   = (req_t'(s_tuser) == REQ_ADD);
    assign full_now = (job_count_reg >= CNT_W'(MAX_JOBS));

    // Table append happens at the accept edge. Picks already in flight only
    // ever read slots below their own count, so the append never disturbs them.
    assign wr.en     = acc && is_add && !full_now;
    assign wr.addr   = job_count_reg[IDX_W-1:0];
    assign wr.prefix = total_reg + PW'(s_tdata[REC_W +: WGT_W]);
    assign wr.rec    = s_tdata[REC_W-1:0];

    assign job_count_next = job_count_reg + CNT_W'(wr.en);
    assign total_next     = wr.en ? wr.prefix : total_reg;

    always_comb begin
        in_next       = '0;
        in_next.vld   = acc;
        // empty table or zero total: nothing to find
        in_next.pick  = !is_add && (job_count_reg != '0) && (total_reg != '0);
        in_next.full  = is_add && full_now;
        in_next.cnt   = job_count_next;
        in_next.total = total_reg;
        in_next.frac  = s_tdata[REC_W + WGT_W +: FRAC_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_count_reg <= '0;
            total_reg     <= '0;
            in_reg        <= '0;
        end else begin
            job_count_reg <= job_count_next;
            total_reg     <= total_next;
            if (en) begin
                in_reg <= in_next;
            end
        end
    end

    // q = floor(frac * total / 2^53); q < total whenever total is nonzero
    wljp_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (in_reg),
        .out_item (mul_out)
    );

    // prefixes are nondecreasing: first slot with prefix > q by binary search
    wljp_search u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .wr       (wr),
        .in_item  (mul_out),
        .out_item (srch_out)
    );

    wljp_ram #(
        .DEPTH(MAX_JOBS),
        .WIDTH(REC_W)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.rec),
        .re    (en),
        .raddr (srch_out.idx),
        .rdata (rec_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg <= '0;
        end else if (en) begin
            fin_reg <= srch_out;
        end
    end

    // adds and failed picks report record zero
    always_comb begin
        res.picked = fin_reg.pick ? rec_rd : '0;
        res.found  = fin_reg.pick;
        res.full   = fin_reg.full;
        res.jobs   = JOBS_W'(fin_reg.cnt);
    end

    wljp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && fin_reg.vld),
        .push_item (res),
        .room      (en),
        .out_vld   (m_tvalid),
        .out_item  (out_item),
        .pop_rdy   (m_tready)
    );

    assign m_tdata = M_TDATA_W'(out_item);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        job_count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count above table size");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> (job_count_reg == $past(job_count_reg) + CNT_W'(1)))
        else $error("append did not advance job count");

    a_refused_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && is_add && full_now) |=> $stable(total_reg) && $stable(job_count_reg))
        else $error("refused add changed the table");

endmodule

/* tb/lottery_pick_checker.sv */
`timescale 1ns / 100ps

module lottery_pick_checker import wljp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // record_index, node_count, random_fraction, 0 pad
    input  logic                 s_tuser,   // req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // picked_record, found, table_full, active_jobs, 0 pad
    output int                   mismatches,
    output int                   pending
);

    // shadow job table
    logic [CNT_W-1:0] jobs_held;
    logic [PW-1:0]    weight_sum;
    logic [REC_W-1:0] slot_rec    [MAX_JOBS];
    logic [PW-1:0]    slot_prefix [MAX_JOBS];

    res_t expected_outcomes[$];

    // apply one request to the shadow table and return the result it owes
    function automatic res_t lottery_outcome(input req_t kind, input logic [REC_W-1:0] rec,
                                             input logic [WGT_W-1:0] wgt,
                                             input logic [FRAC_W-1:0] frac);
        res_t                 r;
        logic [FRAC_W+PW-1:0] product;
        logic [PW-1:0]        draw;
        int                   i;
        r = '0;
        if (kind == REQ_ADD) begin
            if (jobs_held >= CNT_W'(MAX_JOBS)) begin
                r.full = 1'b1;
            end else begin
                weight_sum             = weight_sum + PW'(wgt);
                slot_rec[jobs_held]    = rec;
                slot_prefix[jobs_held] = weight_sum;
                jobs_held              = jobs_held + 1'b1;
            end
        end else if (jobs_held != 0 && weight_sum != 0) begin
            // floor(frac * total / 2^53), then first slot whose prefix exceeds it
            product = frac * weight_sum;
            draw    = product[FRAC_W +: PW];
            for (i = 0; i < MAX_JOBS; i++) begin
                if (!r.found && i < jobs_held && draw < slot_prefix[i]) begin
                    r.found  = 1'b1;
                    r.picked = slot_rec[i];
                end
            end
        end
        r.jobs = JOBS_W'(jobs_held);
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            jobs_held  = '0;
            weight_sum = '0;
            expected_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: rec %0d found %0b full %0b jobs %0d",
                                 got.picked, got.found, got.full, got.jobs);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected rec %0d found %0b full %0b ",
                                      "jobs %0d, got rec %0d found %0b full %0b jobs %0d"},
                                     want.picked, want.found, want.full, want.jobs,
                                     got.picked, got.found, got.full, got.jobs);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(lottery_outcome(req_t'(s_tuser),
                                                            s_tdata[0 +: REC_W],
                                                            s_tdata[REC_W +: WGT_W],
                                                            s_tdata[REC_W+WGT_W +: FRAC_W]));
        end
        pending = expected_outcomes.size();
    end

endmodule

/* tb/weighted_lottery_job_picker_test.sv */
`timescale 1ns / 100ps

module weighted_lottery_job_picker_test;
    import wljp_pkg::*;

    localparam int ITEM_TOTAL   = 850;
    localparam int HOLD_AT      = 60;    // item count that triggers the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 20;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // record_index, node_count, random_fraction, 0 pad
    logic                 s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // picked_record, found, table_full, active_jobs, 0 pad

    int mismatches;
    int pending;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    bit hold_done;

    // stimulus-side view of the table, used only to aim fractions at slot edges
    logic [PW-1:0] issued_prefix [MAX_JOBS];
    int            issued_jobs;
    logic [PW-1:0] issued_total;

    weighted_lottery_job_picker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lottery_pick_checker pick_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Smallest fraction whose draw reaches target (below = 0), or the largest
    // one that stays under it (below = 1). Needs a nonzero total.
    function automatic logic [FRAC_W-1:0] fraction_at(input logic [PW-1:0] target,
                                                      input bit below);
        logic [FRAC_W+PW-1:0] f;
        f = ({target, {FRAC_W{1'b0}}} + issued_total - 1) / issued_total;
        if (f[FRAC_W+PW-1:FRAC_W] != 0)
            return '1;
        if (below && f != 0)
            f = f - 1;
        return f[FRAC_W-1:0];
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3, 4: begin
                // hit either side of a slot boundary
                if (issued_total != 0)
                    return fraction_at(issued_prefix[$urandom_range(issued_jobs - 1)],
                                       $urandom_range(1));
                return FRAC_W'({$urandom, $urandom});
            end
            default: return FRAC_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] random_weight();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return WGT_W'($urandom_range(1, 15));
            default: return WGT_W'($urandom);
        endcase
    endfunction

    // Present one item from a falling edge and hold it until accepted.
    // Returns at the falling edge after the handshake.
    task automatic offer(input req_t kind, input logic [REC_W-1:0] rec,
                         input logic [WGT_W-1:0] wgt, input logic [FRAC_W-1:0] frac);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({frac, wgt, rec});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (kind == REQ_ADD && issued_jobs < MAX_JOBS) begin
            issued_total               = issued_total + PW'(wgt);
            issued_prefix[issued_jobs] = issued_total;
            issued_jobs++;
        end
        @(negedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off so the pipe backs up
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: any handshake resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("weighted_lottery_job_picker verification failed");
                $finish;
            end
        end
    end

    initial begin
        req_t kind;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issued_jobs    = 0;
        issued_total   = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: nothing to pick
        offer(REQ_PICK, '1, '1, '0);
        offer(REQ_PICK, '0, '0, '1);
        // zero-weight job alone: total is zero, still nothing to pick
        offer(REQ_ADD, '0, '0, '1);
        offer(REQ_PICK, '1, '1, FRAC_W'({$urandom, $urandom}));
        offer(REQ_PICK, '1, '1, '1);
        // heaviest job behind it; the zero-weight slot must be skipped
        offer(REQ_ADD, '1, '1, '0);
        offer(REQ_PICK, '0, '0, '0);
        offer(REQ_PICK, '0, '0, '1);
        // weight-one job: exact compare right at its boundary
        offer(REQ_ADD, REC_W'(21), WGT_W'(1), '1);
        offer(REQ_PICK, '0, '0, fraction_at(PW'(65535), 1'b0));
        offer(REQ_PICK, '0, '0, fraction_at(PW'(65535), 1'b1));
        offer(REQ_PICK, '0, '0, '1);
        // zero weight in the middle, then alternating bit patterns
        offer(REQ_ADD, REC_W'(42), '0, '0);
        offer(REQ_ADD, REC_W'(21), WGT_W'(16'h5555), '0);
        offer(REQ_ADD, REC_W'(42), WGT_W'(16'hAAAA), '1);
        offer(REQ_PICK, '0, '0, fraction_at(issued_prefix[3], 1'b0));
        offer(REQ_PICK, '0, '0, fraction_at(issued_prefix[3], 1'b1));
        offer(REQ_PICK, '0, '0, fraction_at(issued_prefix[4], 1'b1));

        // Random traffic: about one add in seven fills the table near the middle
        // of the run; later adds are refused. Idle phases by item count.
        while (items_sent < ITEM_TOTAL) begin
            if (items_sent < 220) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (items_sent < 430) begin
                send_idle_pct  = 45;
                recv_stall_pct = 0;
            end else if (items_sent < 640) begin
                send_idle_pct  = 0;
                recv_stall_pct = 45;
            end else begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
            kind = ($urandom_range(6) == 0) ? REQ_ADD : REQ_PICK;
            offer(kind, REC_W'($urandom_range(63)), random_weight(), random_fraction());
        end

        // drain: open the receiver and wait for every outstanding result
        s_tvalid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("weighted_lottery_job_picker verification clean");
        end else begin
            $display("weighted_lottery_job_picker verification failed");
        end
        $finish;
    end

endmodule
